FILE: src/vax_ieee_float_converter_unit_macros.svh
// Assertion macros used by the float converter checker.
`ifndef VAX_IEEE_FLOAT_CONVERTER_UNIT_MACROS_SVH
`define VAX_IEEE_FLOAT_CONVERTER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define VIFC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define VIFC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/vifc_pkg.sv
// Types, codes and constants of the VAX / IEEE float converter.
package vifc_pkg;

	typedef enum logic [1:0] {
		FMT_VAXF  = 2'd0,
		FMT_VAXD  = 2'd1,
		FMT_IEEES = 2'd2,
		FMT_IEEET = 2'd3
	} fmt_t;

	typedef enum logic [2:0] {
		ST_NORMAL  = 3'd0,
		ST_NEG_INF = 3'd1,
		ST_POS_INF = 3'd2,
		ST_INVALID = 3'd3,
		ST_OVERFLOW = 3'd4
	} status_t;

	// What the packing stage drives out.
	typedef enum logic [2:0] {
		SEL_ZERO,
		SEL_VAX_ROP,
		SEL_SGL_NAN,
		SEL_DBL_NAN,
		SEL_PACK
	} sel_t;

	localparam int ExpW  = 11;
	localparam int FracW = 55;   // fraction bits 63..9 of the left-aligned fraction

	localparam logic [31:0] VaxRop     = 32'h0000_8000;
	localparam logic [31:0] SglNan     = 32'h7fbf_ffff;
	localparam logic [63:0] DblNan     = 64'h7ff7_ffff_ffff_ffff;
	localparam logic [30:0] SglInfMag  = 31'h7f80_0000;
	localparam logic [62:0] DblInfMag  = 63'h7ff0_0000_0000_0000;
	localparam logic [7:0]  VaxExpTop  = 8'd254;
	localparam logic [7:0]  SglExpMax  = 8'hff;
	localparam logic [7:0]  SglExpOver = 8'hfe;
	localparam logic [10:0] DblExpMax  = 11'h7ff;
	localparam logic [10:0] DblExpOver = 11'h7fe;

	function automatic logic [ExpW-1:0] fmt_bias(fmt_t f);
		logic [ExpW-1:0] b;
		case (f)
			FMT_IEEES: b = 11'd126;
			FMT_IEEET: b = 11'd1022;
			default:   b = 11'd128;
		endcase
		return b;
	endfunction

	function automatic logic fmt_is_vax(fmt_t f);
		return (f == FMT_VAXF) || (f == FMT_VAXD);
	endfunction

endpackage

FILE: src/vax_ieee_float_converter_unit.sv
// Top level: three-stage VAX F/D and IEEE single/double format converter.
//
//   channel | direction | handshake             | payload
//   in      | request   | in_valid / in_stall   | raw_value, source_format, target_format
//   out     | result    | out_valid / out_stall | converted_value, status
//
// Stages: unpack, exponent rebias, repack into the output register.
// One request enters per cycle while in_stall is low; each stage holds only when the
// stage after it is full and held, so a full pipe carries three requests.
// in_stall rises only when all three stages are full and out_stall is high.
// arst_n clears the stage valid bits; data registers are not reset.
module vax_ieee_float_converter_unit
	import vifc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] raw_value,
	input  logic [1:0]  source_format,
	input  logic [1:0]  target_format,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] converted_value,
	output logic [2:0]  status
);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	assign en_s3    = !v_s3 || !out_stall;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// ---------------- stage 1: unpack ----------------
	fmt_t             sf, tf;
	logic [31:0]      lo, hi;
	logic             u_sign, u_zero, u_nan, u_inf, u_over;
	logic [ExpW-1:0]  u_ex;
	logic [FracW-1:0] u_frac;

	assign sf = fmt_t'(source_format);
	assign tf = fmt_t'(target_format);
	assign lo = raw_value[31:0];
	assign hi = raw_value[63:32];

	always_comb begin
		u_sign = 1'b0;
		u_ex   = '0;
		u_frac = '0;
		u_zero = 1'b0;
		u_nan  = 1'b0;
		u_inf  = 1'b0;
		u_over = 1'b0;
		unique case (sf)
			FMT_VAXF, FMT_VAXD: begin
				u_sign = lo[15];
				u_ex   = {3'b000, lo[14:7]};
				if (sf == FMT_VAXD) begin
					u_frac = {lo[6:0], lo[31:16], hi[15:0], hi[31:16]};
					u_nan  = (lo == VaxRop) && (hi == 32'd0);
				end else begin
					u_frac = {lo[6:0], lo[31:16], 32'd0};
					u_nan  = (lo == VaxRop);
				end
				// exponent zero or at the top of the range reads as zero
				u_zero = ((lo[14:7] == 8'd0) || (lo[14:7] >= VaxExpTop)) && !u_nan;
			end
			FMT_IEEES: begin
				u_sign = lo[31];
				u_ex   = {3'b000, lo[30:23]};
				u_frac = {lo[22:0], 32'd0};
				u_zero = (lo[30:0] == 31'd0);
				u_inf  = (lo[30:0] == SglInfMag);
				u_over = (lo[30:23] == SglExpOver);
				u_nan  = (lo[30:23] == SglExpMax);
			end
			FMT_IEEET: begin
				u_sign = raw_value[63];
				u_ex   = raw_value[62:52];
				u_frac = {raw_value[51:0], 3'b000};
				u_zero = (raw_value[62:0] == 63'd0);
				u_inf  = (raw_value[62:0] == DblInfMag);
				u_over = (raw_value[62:52] == DblExpOver);
				u_nan  = (raw_value[62:52] == DblExpMax);
			end
			default: ;
		endcase
	end

	logic             sign_s1, zero_s1, nan_s1, inf_s1, over_s1;
	logic [ExpW-1:0]  ex_s1;
	logic [FracW-1:0] frac_s1;
	fmt_t             sf_s1, tf_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			sign_s1 <= u_sign;
			ex_s1   <= u_ex;
			frac_s1 <= u_frac;
			zero_s1 <= u_zero;
			nan_s1  <= u_nan;
			inf_s1  <= u_inf;
			over_s1 <= u_over;
			sf_s1   <= sf;
			tf_s1   <= tf;
		end
	end

	// ---------------- stage 2: rebias, classify ----------------
	logic [ExpW-1:0] r_exp;
	sel_t            r_sel;
	status_t         r_status;
	logic            r_rop;

	assign r_exp = ex_s1 - fmt_bias(sf_s1) + fmt_bias(tf_s1);
	// IEEE invalid or top-exponent input becomes a VAX reserved operand
	assign r_rop = !fmt_is_vax(sf_s1) && (over_s1 || nan_s1);

	always_comb begin
		r_sel = SEL_PACK;
		if (fmt_is_vax(tf_s1)) begin
			if (zero_s1)    r_sel = SEL_ZERO;
			else if (r_rop) r_sel = SEL_VAX_ROP;
		end else begin
			if (nan_s1)       r_sel = (tf_s1 == FMT_IEEES) ? SEL_SGL_NAN : SEL_DBL_NAN;
			else if (zero_s1) r_sel = SEL_ZERO;
		end

		if (inf_s1 && sign_s1) r_status = ST_NEG_INF;
		else if (inf_s1)       r_status = ST_POS_INF;
		else if (nan_s1)       r_status = ST_INVALID;
		else if (over_s1)      r_status = ST_OVERFLOW;
		else                   r_status = ST_NORMAL;
	end

	logic             sign_s2;
	logic [ExpW-1:0]  exp_s2;
	logic [FracW-1:0] frac_s2;
	sel_t             sel_s2;
	status_t          status_s2;
	fmt_t             tf_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sign_s2   <= sign_s1;
			exp_s2    <= r_exp;
			frac_s2   <= frac_s1;
			sel_s2    <= r_sel;
			status_s2 <= r_status;
			tf_s2     <= tf_s1;
		end
	end

	// ---------------- stage 3: repack ----------------
	logic [63:0] p_word;

	always_comb begin
		p_word = '0;
		case (sel_s2)
			SEL_ZERO:    p_word = '0;
			SEL_VAX_ROP: p_word = {32'd0, VaxRop};
			SEL_SGL_NAN: p_word = {32'd0, SglNan};
			SEL_DBL_NAN: p_word = DblNan;
			default: begin
				unique case (tf_s2)
					FMT_VAXF: p_word = {32'd0, frac_s2[47:32], sign_s2, exp_s2[7:0],
						frac_s2[54:48]};
					FMT_VAXD: p_word = {frac_s2[15:0], frac_s2[31:16], frac_s2[47:32],
						sign_s2, exp_s2[7:0], frac_s2[54:48]};
					FMT_IEEES: p_word = {32'd0, sign_s2, exp_s2[7:0], frac_s2[54:32]};
					FMT_IEEET: p_word = {sign_s2, exp_s2, frac_s2[54:3]};
					default: p_word = '0;
				endcase
			end
		endcase
	end

	logic [63:0] value_s3;
	status_t     status_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			value_s3  <= p_word;
			status_s3 <= status_s2;
		end
	end

	assign out_valid       = v_s3;
	assign converted_value = value_s3;
	assign status          = status_s3;

endmodule

FILE: src/vifc_checker.sv
// Port-level checker for the float converter, bound to the top level.
`include "vax_ieee_float_converter_unit_macros.svh"

module vifc_checker
	import vifc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [63:0] converted_value,
	input logic [2:0]  status
);

	logic special_word;

	assign special_word = (converted_value == {32'd0, VaxRop}) ||
		(converted_value == {32'd0, SglNan}) || (converted_value == DblNan);

	// a held result keeps its value
	`VIFC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(converted_value) && $stable(status), "result changed while held")

	// input back-pressure only with a full, held output
	`VIFC_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall,
		out_valid && out_stall, "input stalled without output back-pressure")

	// infinity and invalid inputs always map to a fixed pattern
	`VIFC_ASSERT_NOW(a_special_word, clk, arst_n,
		out_valid && (status == ST_NEG_INF || status == ST_POS_INF || status == ST_INVALID),
		special_word, "special status without its fixed pattern")

	// nothing comes out in the cycle after reset
	`VIFC_ASSERT_NOW(a_reset_empty, clk, arst_n, !$past(arst_n),
		!out_valid, "result present right after reset")

endmodule

bind vax_ieee_float_converter_unit vifc_checker u_vifc_checker (.*);
